[sv/rtcm3_pkg.sv]
package rtcm3_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 24;
    localparam int unsigned IDX_W  = 11;
    localparam int unsigned LEN_W  = 10;
    localparam int unsigned TYPE_W = 12;

    // CRC-24Q polynomial 0x1864CFB with the implicit x^24 term dropped
    localparam logic [CRC_W-1:0] CRC_POLY = 24'h864CFB;
    localparam logic [BYTE_W-1:0] PREAMBLE_RESET = 8'hD3;

    typedef enum logic [1:0] {
        K_START = 2'd0,   // preamble byte, opens a frame
        K_CRC   = 2'd1,   // header or payload byte, covered by the CRC
        K_TRAIL = 2'd2,   // trailing CRC byte
        K_FINAL = 2'd3    // last trailing CRC byte, closes the frame
    } t_kind;

    typedef enum logic [1:0] {
        TS_NONE = 2'd0,
        TS_HIGH = 2'd1,   // frame byte 3: type bits 11..4
        TS_LOW  = 2'd2    // frame byte 4: type bits 3..0
    } t_type_sel;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_CRC_FAIL   = 2'd1,
        ST_INCOMPLETE = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        t_type_sel          type_sel;
        logic               last;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   length;
    } t_token;

    function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 16'h0000};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[sv/rtcm3_in_if.sv]
interface rtcm3_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       buffer_end;

    modport source (output valid, output byte_in, output buffer_end, input ready);
    modport sink   (input valid, input byte_in, input buffer_end, output ready);
endinterface

[sv/rtcm3_out_if.sv]
interface rtcm3_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] message_type;
    logic [9:0]  payload_length;
    logic [23:0] crc_received;
    logic [23:0] crc_computed;
    logic [1:0]  frame_status;

    modport source (output valid, output message_type, output payload_length,
                    output crc_received, output crc_computed, output frame_status,
                    input ready);
    modport sink   (input valid, input message_type, input payload_length,
                    input crc_received, input crc_computed, input frame_status,
                    output ready);
endinterface

[sv/rtcm3_front.sv]
module rtcm3_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [7:0]                i_cfg_wdata,
    rtcm3_in_if.sink                  i_in,
    input  logic                      i_q_ready,
    output logic                      o_q_push,
    output rtcm3_pkg::t_token         o_q_token
);
    import rtcm3_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_TRAILER = 4'b1000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [BYTE_W-1:0]  r_preamble;

    logic               accept;
    logic               frame_done;
    logic [IDX_W-1:0]   len_ext;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign len_ext    = {1'b0, r_len};

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_len      = r_len;
        frame_done = 1'b0;
        o_q_push   = 1'b0;
        o_q_token.kind     = K_CRC;
        o_q_token.type_sel = TS_NONE;
        o_q_token.last     = i_in.buffer_end;
        o_q_token.data     = i_in.byte_in;
        o_q_token.length   = r_len;

        if (accept) begin
            if (r_phase == PH_HUNT) begin
                if (i_in.byte_in == r_preamble) begin
                    o_q_push         = 1'b1;
                    o_q_token.kind   = K_START;
                    o_q_token.length = '0;
                    if (!i_in.buffer_end) begin
                        n_phase = PH_HEADER;
                        n_idx   = IDX_W'(1);
                        n_len   = '0;
                    end
                end
            end else begin
                o_q_push = 1'b1;
                if (r_idx == IDX_W'(3)) begin
                    o_q_token.type_sel = TS_HIGH;
                end else if (r_idx == IDX_W'(4)) begin
                    o_q_token.type_sel = TS_LOW;
                end
                case (r_phase)
                    PH_HEADER: begin
                        if (r_idx == IDX_W'(1)) begin
                            n_len = {i_in.byte_in[1:0], 8'h00};
                        end else begin
                            n_len   = r_len | {2'b00, i_in.byte_in};
                            n_phase = (n_len == '0) ? PH_TRAILER : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (r_idx >= IDX_W'(2) + len_ext) begin
                            n_phase = PH_TRAILER;
                        end
                    end
                    default: begin
                        o_q_token.kind = K_TRAIL;
                        if (r_idx >= len_ext + IDX_W'(5)) begin
                            o_q_token.kind = K_FINAL;
                            frame_done     = 1'b1;
                        end
                    end
                endcase
                o_q_token.length = n_len;
                n_idx = r_idx + IDX_W'(1);
                // a buffer end inside the frame drops it; the final byte wins
                if (frame_done || i_in.buffer_end) begin
                    n_phase = PH_HUNT;
                    n_idx   = '0;
                    n_len   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_idx      <= '0;
            r_len      <= '0;
            r_preamble <= PREAMBLE_RESET;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
            if (i_cfg_we) begin
                r_preamble <= i_cfg_wdata;
            end
        end
    end

    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_idx == '0 && r_len == '0))
        else $error("front: frame counters not cleared while hunting");

endmodule

[sv/rtcm3_queue.sv]
module rtcm3_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  rtcm3_pkg::t_token         i_token,
    output logic                      o_ready,
    input  logic                      i_pop,
    output logic                      o_valid,
    output rtcm3_pkg::t_token         o_token
);
    import rtcm3_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue: occupancy beyond depth");

endmodule

[sv/rtcm3_back.sv]
module rtcm3_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  rtcm3_pkg::t_token         i_q_token,
    output logic                      o_q_pop,
    rtcm3_out_if.source               o_out
);
    import rtcm3_pkg::*;

    logic [TYPE_W-1:0]  r_type_acc, n_type_acc;
    logic [CRC_W-1:0]   r_crc_acc, n_crc_acc;
    logic [CRC_W-1:0]   r_trail_acc, n_trail_acc;

    logic               r_valid;
    logic [TYPE_W-1:0]  r_type;
    logic [LEN_W-1:0]   r_len;
    logic [CRC_W-1:0]   r_crc_rx;
    logic [CRC_W-1:0]   r_crc_cmp;
    t_status            r_status;

    logic               emit;
    t_status            emit_status;
    logic [CRC_W-1:0]   emit_rx, emit_calc;

    assign o_q_pop = i_q_valid && (!r_valid || o_out.ready);

    always_comb begin
        n_type_acc  = (i_q_token.kind == K_START) ? '0 : r_type_acc;
        n_crc_acc   = r_crc_acc;
        n_trail_acc = r_trail_acc;
        emit        = 1'b0;
        emit_status = ST_INCOMPLETE;
        emit_rx     = '0;
        emit_calc   = '0;

        // type bits follow frame position, even into the trailer
        case (i_q_token.type_sel)
            TS_HIGH: n_type_acc = {i_q_token.data, 4'h0};
            TS_LOW:  n_type_acc = n_type_acc | {8'h00, i_q_token.data[7:4]};
            default: ;
        endcase

        case (i_q_token.kind)
            K_START: begin
                n_crc_acc   = crc24q_byte('0, i_q_token.data);
                n_trail_acc = '0;
                emit        = i_q_token.last;
            end
            K_CRC: begin
                n_crc_acc = crc24q_byte(r_crc_acc, i_q_token.data);
                emit      = i_q_token.last;
            end
            K_TRAIL: begin
                n_trail_acc = {r_trail_acc[CRC_W-9:0], i_q_token.data};
                emit        = i_q_token.last;
            end
            default: begin
                n_trail_acc = {r_trail_acc[CRC_W-9:0], i_q_token.data};
                emit        = 1'b1;
                emit_rx     = n_trail_acc;
                emit_calc   = r_crc_acc;
                emit_status = (n_trail_acc == r_crc_acc) ? ST_OK : ST_CRC_FAIL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_type_acc  <= n_type_acc;
            r_crc_acc   <= n_crc_acc;
            r_trail_acc <= n_trail_acc;
        end
        if (o_q_pop && emit) begin
            r_type     <= n_type_acc;
            r_len      <= i_q_token.length;
            r_crc_rx   <= emit_rx;
            r_crc_cmp  <= emit_calc;
            r_status   <= emit_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop && emit) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.message_type   = r_type;
    assign o_out.payload_length = r_len;
    assign o_out.crc_received   = r_crc_rx;
    assign o_out.crc_computed   = r_crc_cmp;
    assign o_out.frame_status   = r_status;

    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_token.kind == K_FINAL)
            |=> (r_valid && r_status != ST_INCOMPLETE))
        else $error("back: frame close did not give a checked result");

    a_incomplete_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_INCOMPLETE) |-> (r_crc_rx == '0 && r_crc_cmp == '0))
        else $error("back: incomplete result carries CRC values");

endmodule

[sv/rtcm3_frame_checker.sv]
// Channel  | Dir | Handshake     | Transaction payload
// i_in     | in  | valid / ready | byte_in[7:0], buffer_end
// o_out    | out | valid / ready | message_type[11:0], payload_length[9:0],
//          |     |               | crc_received[23:0], crc_computed[23:0], frame_status[1:0]
// i_cfg_*  | in  | write enable  | preamble byte[7:0]
//
// One byte per cycle while the token queue has room; the CRC-24Q byte update is
// combinational XOR logic. The front is combinational; each taken frame byte becomes a
// queued token, and the back end registers the result when it pops the frame's last token.
// Synchronous active-low reset; preamble returns to 0xD3, no clearing pass.
// A stalled output backs up the token queue; input ready drops only when it is full.
module rtcm3_frame_checker #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    rtcm3_in_if.sink    i_in,
    rtcm3_out_if.source o_out
);
    import rtcm3_pkg::*;

    logic   q_push, q_ready, q_pop, q_valid;
    t_token push_token, pop_token;

    rtcm3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_ready   (q_ready),
        .o_q_push    (q_push),
        .o_q_token   (push_token)
    );

    rtcm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_token (push_token),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_token (pop_token)
    );

    rtcm3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_token (pop_token),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
